// File: rtl/rgb3x3_pkg.sv
// rgb3x3_pkg: types and constants shared by the rgb 3x3 convolution filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rgb3x3_pkg;

  localparam int unsigned ChW = 12;
  localparam int unsigned ChMax = 4080;

  typedef enum logic [1:0] {
    FM_EDGE    = 2'd0,
    FM_SHARPEN = 2'd1,
    FM_BOX     = 2'd2,
    FM_GAUSS   = 2'd3
  } filt_mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_XSTART = 3'd3,
    REG_XEND   = 3'd4,
    REG_YSTART = 3'd5,
    REG_YEND   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] red_in;
    logic [11:0] green_in;
    logic [11:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic [11:0] red_out;
    logic [11:0] green_out;
    logic [11:0] blue_out;
    logic        last_of_region;
  } pix_out_t;

  typedef logic [ChW-1:0] ch_t;
  typedef ch_t [2:0] rgb_t;

  // one window (9 taps per channel) plus tag, front to back
  typedef struct packed {
    rgb_t [2:0][2:0] win;
    logic [1:0]      mode;
    logic [11:0]     row;
    logic [10:0]     col;
    logic            last;
  } job_t;

  // box blur: floor(s/9) for s < 36864 via (s*7281)>>16 then one correction
  function automatic ch_t div9(input logic [15:0] s);
    logic [28:0] p;
    logic [15:0] q;
    logic [15:0] r;
    begin
      p = s * 13'd7281;
      q = {3'd0, p[28:16]};
      r = s - q * 16'd9;
      if (r >= 16'd9) q = q + 16'd1;
      div9 = (q > 16'(ChMax)) ? ch_t'(ChMax) : q[ChW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/rgb_3x3_convolution_filter.sv
// rgb_3x3_convolution_filter: top level, config registers and front/back split
// depends on rgb3x3_pkg, rgb3x3_front, rgb3x3_back
`timescale 1ns / 1ps
`default_nettype none
// Takes one RGB pixel per clock in raster order while full is low and returns each
// filtered pixel of the reduced selection through a result queue; one beat per
// cycle is sustained while the result side keeps popping. full rises when the
// result queue holds more than two entries, since the line store, window and two
// kernel stages still hold up to four beats. Line stores are undefined after reset
// and need no clearing. Write configuration only when idle.
module rgb_3x3_convolution_filter import rgb3x3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire pix_in_t     pix_i,
  output logic             empty,
  input  wire logic        pop,
  output pix_out_t         res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i
);
  logic [1:0]  mode_q;
  logic [11:0] width_q, xe_q, ys_q;
  logic [12:0] height_q, ye_q;
  logic [10:0] xs_q;
  logic        stall, job_vld;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      width_q  <= 12'd2048;
      height_q <= 13'd4096;
      xs_q     <= '0;
      xe_q     <= 12'd2048;
      ys_q     <= '0;
      ye_q     <= 13'd4096;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[11:0];
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_XSTART: xs_q     <= cfg_data_i[10:0];
        REG_XEND:   xe_q     <= cfg_data_i[11:0];
        REG_YSTART: ys_q     <= cfg_data_i[11:0];
        REG_YEND:   ye_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rgb3x3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni, .push_i(push), .pix_i, .stall_i(stall),
    .mode_i(mode_q), .width_i(width_q), .height_i(height_q),
    .xs_i(xs_q), .xe_i(xe_q), .ys_i(ys_q), .ye_i(ye_q),
    .full_o(full), .job_vld_o(job_vld), .job_o(job)
  );

  rgb3x3_back u_back (
    .clk_i, .rst_ni, .job_vld_i(job_vld), .job_i(job), .stall_o(stall),
    .pop_i(pop), .empty_o(empty), .res_o
  );
endmodule
`default_nettype wire

// File: rtl/rgb3x3_front.sv
// rgb3x3_front: pixel intake, line stores, window and region classification
// depends on rgb3x3_pkg
`timescale 1ns / 1ps
`default_nettype none
module rgb3x3_front import rgb3x3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire pix_in_t    pix_i,
  input  wire logic       stall_i,
  input  wire logic [1:0] mode_i,
  input  wire logic [11:0] width_i,
  input  wire logic [12:0] height_i,
  input  wire logic [10:0] xs_i,
  input  wire logic [11:0] xe_i,
  input  wire logic [11:0] ys_i,
  input  wire logic [12:0] ye_i,
  output logic            full_o,
  output logic            job_vld_o,
  output job_t            job_o
);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW = 3 * ChW;

  logic [LW-1:0] upper_mem [MAX_WIDTH];
  logic [LW-1:0] mid_mem [MAX_WIDTH];

  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [XW-1:0] w, tx1, tx2;
  logic [YW-1:0] h, ty1, ty2;
  logic          acc;

  // stage 1 registers: new pixel, line reads, tag
  logic          s1_vld_q;
  logic [LW-1:0] s1_pix_q, s1_up_q, s1_mid_q;
  logic          s1_emit_q, s1_last_q;
  logic [XW-1:0] s1_cc_q;
  logic [YW-1:0] s1_rr_q;

  rgb_t [2:0][2:0] win_q, win_d;
  logic            emit, last;
  logic [XW-1:0]   cc;
  logic [YW-1:0]   rr;

  assign full_o = stall_i;
  assign acc    = push_i && !stall_i;

  always_comb begin
    w = (XW'(width_i) < XW'(3)) ? XW'(3) :
        (XW'(width_i) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(width_i);
    if ((XW > 12) ? 1'b0 : (32'(width_i) > MAX_WIDTH)) w = XW'(MAX_WIDTH);
    if (32'(width_i) < 3) w = XW'(3);
    h = (32'(height_i) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_i);
    if (32'(height_i) < 3) h = YW'(3);
    tx1 = (xs_i == '0) ? XW'(1) : XW'(xs_i);
    tx2 = (32'(xe_i) == 32'(w)) ? w - XW'(1) : XW'(xe_i);
    if (32'(xe_i) > 32'(w) - 1) tx2 = w - XW'(1);
    ty1 = (ys_i == '0) ? YW'(1) : YW'(ys_i);
    ty2 = (32'(ye_i) == 32'(h)) ? h - YW'(1) : YW'(ye_i);
    if (32'(ye_i) > 32'(h) - 1) ty2 = h - YW'(1);
    cc   = col_q - XW'(1);
    rr   = row_q - YW'(1);
    emit = (col_q != '0) && (row_q != '0) && (cc >= tx1) && (cc < tx2) &&
           (rr >= ty1) && (rr < ty2);
    last = (cc == tx2 - XW'(1)) && (rr == ty2 - YW'(1));
    col_d = col_q + XW'(1);
    row_d = row_q;
    if (col_d >= w) begin
      col_d = '0;
      row_d = row_q + YW'(1);
      if (row_d >= h) row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_up_q  <= upper_mem[col_q[AW-1:0]];
      s1_mid_q <= mid_mem[col_q[AW-1:0]];
      s1_pix_q <= pix_i;
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_cc_q  <= cc;
      s1_rr_q  <= rr;
    end
  end

  // line stores written from the stage 1 registers
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      upper_mem[s1_cc_q[AW-1:0] + AW'(1)] <= s1_mid_q;
      mid_mem[s1_cc_q[AW-1:0] + AW'(1)]   <= s1_pix_q;
    end
  end

  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = s1_up_q;
    win_d[1][2] = s1_mid_q;
    win_d[2][2] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      job_vld_o <= 1'b0;
    end else begin
      job_vld_o <= s1_vld_q && s1_emit_q;
      if (s1_vld_q) win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      job_o.win  <= win_d;
      job_o.mode <= mode_i;
      job_o.row  <= s1_rr_q[11:0];
      job_o.col  <= s1_cc_q[10:0];
      job_o.last <= s1_last_q;
    end
  end
endmodule
`default_nettype wire

// File: rtl/rgb3x3_back.sv
// rgb3x3_back: job queue, kernel arithmetic and result queue
// depends on rgb3x3_pkg
`timescale 1ns / 1ps
`default_nettype none
module rgb3x3_back import rgb3x3_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_vld_i,
  input  wire job_t     job_i,
  output logic          stall_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output pix_out_t      res_o
);
  // result queue sized to cover the beats held in the front and compute stages
  localparam int unsigned Depth = 8;
  localparam int unsigned PW = $clog2(Depth);

  // stage a: partial sums
  logic        a_vld_q;
  logic [15:0] a_c_q [3], a_x_q [3], a_k_q [3];
  logic [1:0]  a_mode_q;
  logic [11:0] a_row_q;
  logic [10:0] a_col_q;
  logic        a_last_q;
  // stage b: result
  logic        b_vld_q;
  pix_out_t    b_q;
  rgb_t        res_d;

  pix_out_t    fifo_q [Depth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          wr, rd;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      a_c_q[c] <= 16'(job_i.win[1][1][c]);
      a_x_q[c] <= 16'(job_i.win[0][1][c]) + 16'(job_i.win[1][0][c]) +
                  16'(job_i.win[1][2][c]) + 16'(job_i.win[2][1][c]);
      a_k_q[c] <= 16'(job_i.win[0][0][c]) + 16'(job_i.win[0][2][c]) +
                  16'(job_i.win[2][0][c]) + 16'(job_i.win[2][2][c]);
    end
    a_mode_q <= job_i.mode;
    a_row_q  <= job_i.row;
    a_col_q  <= job_i.col;
    a_last_q <= job_i.last;
  end

  always_comb begin
    logic signed [18:0] s;
    for (int c = 0; c < 3; c++) begin
      s = '0;
      res_d[c] = '0;
      case (filt_mode_e'(a_mode_q))
        FM_EDGE: s = 19'(a_c_q[c]) * 19'sd8 - 19'(a_x_q[c]) - 19'(a_k_q[c]);
        FM_SHARPEN: s = 19'(a_c_q[c]) * 19'sd5 - 19'(a_x_q[c]);
        FM_GAUSS: s = 19'((19'(a_c_q[c]) * 19'd4 + 19'(a_x_q[c]) * 19'd2 +
                          19'(a_k_q[c])) >> 4);
        default: s = '0;
      endcase
      if (filt_mode_e'(a_mode_q) == FM_BOX)
        res_d[c] = div9(a_c_q[c] + a_x_q[c] + a_k_q[c]);
      else if (s < 0) res_d[c] = '0;
      else if (s > 19'sd4080) res_d[c] = ch_t'(ChMax);
      else res_d[c] = s[ChW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    b_q.out_row        <= a_row_q;
    b_q.out_col        <= a_col_q;
    b_q.red_out        <= res_d[2];
    b_q.green_out      <= res_d[1];
    b_q.blue_out       <= res_d[0];
    b_q.last_of_region <= a_last_q;
  end

  assign wr = b_vld_q;
  assign rd = pop_i && !empty_o;
  assign empty_o = (cnt_q == '0);
  assign res_o = fifo_q[rp_q];
  // in flight can reach four beats; keep room for all of them
  assign stall_o = (cnt_q > (PW + 1)'(Depth - 6));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
    end else begin
      a_vld_q <= job_vld_i;
      b_vld_q <= a_vld_q;
      if (wr) wp_q <= wp_q + PW'(1);
      if (rd) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW + 1)'(wr) - (PW + 1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) fifo_q[wp_q] <= b_q;
  end
endmodule
`default_nettype wire

// File: rtl/rgb3x3_chk.sv
// rgb3x3_chk: port-level checks for the rgb 3x3 convolution filter
// depends on rgb3x3_pkg and rgb_3x3_convolution_filter
`timescale 1ns / 1ps
`default_nettype none
module rgb3x3_chk import rgb3x3_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     push,
  input wire logic     full,
  input wire logic     empty,
  input wire logic     pop,
  input wire pix_out_t res_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(res_o)) else $error("result beat changed");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.red_out <= 12'd4080 && res_o.green_out <= 12'd4080 &&
    res_o.blue_out <= 12'd4080) else $error("channel over clamp");
  a_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.out_col != '0 && res_o.out_row != '0) else $error("edge pixel out");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop)) else $error("result lost");
endmodule
bind rgb_3x3_convolution_filter rgb3x3_chk u_chk (.*);
`default_nettype wire
